@@ hdl/assert_macros.svh @@
// assertion macros shared by the lockout table rtl
// no dependencies; empty bodies under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hdl/crlt_pkg.sv @@
// shared types and constants for the crash rate lockout table
// no dependencies
package crlt_pkg;
    localparam int unsigned ENTRIES_DEF = 64;
    localparam logic [31:0] EXPIRY_RESET = 32'd120;
    localparam logic [31:0] SUSPEND_RESET = 32'd600;
    localparam logic [7:0] MAX_RESET = 8'd5;
    localparam int unsigned TIME_W = 41;
    localparam int unsigned KEY_W = 112;
    localparam int unsigned QDEPTH = 2;

    typedef enum logic [1:0] {
        OP_CRASH = 2'd0,
        OP_CHECK = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_ALLOW = 2'd0,
        ST_DENY = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_EXPIRY = 2'd0,
        REG_SUSPEND = 2'd1,
        REG_MAX = 2'd2
    } reg_idx_t;

    // classified command handed from front to back
    typedef struct packed {
        logic scan;          // needs a table scan
        op_t op;
        logic [KEY_W-1:0] key;
        logic [39:0] now;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic found;
        logic [7:0] crash_count;
        logic suspended_now;
    } result_t;
endpackage

@@ hdl/crlt_ram.sv @@
// generic single port ram with registered read
// no dependencies
module crlt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input logic clk,
    input logic we,
    input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

@@ hdl/crlt_front.sv @@
// front end: accepts transactions, classifies them, queues commands
// depends on crlt_pkg
module crlt_front (
    input logic clk,
    input logic rst_n,
    input logic push,
    output logic full,
    input logic [1:0] op,
    input logic guard_active,
    input logic [31:0] user_id,
    input logic [63:0] file_id,
    input logic [15:0] mount_id,
    input logic [39:0] now,
    output logic cmd_valid,
    input logic cmd_take,
    output crlt_pkg::cmd_t cmd
);
    import crlt_pkg::*;
    localparam int unsigned PW = $clog2(QDEPTH);

    cmd_t q_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0] cnt_reg;
    cmd_t c;
    logic acc;

    always_comb
    begin
        c.op = op_t'(op);
        c.key = {user_id, file_id, mount_id};
        c.now = now;
        // guard off makes crash and check a no-op; op 3 is a no-op
        c.scan = (op == OP_REMOVE) ||
            (guard_active && (op == OP_CRASH || op == OP_CHECK));
    end

    assign full = (cnt_reg == (PW+1)'(QDEPTH));
    assign acc = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (acc)
            q_reg[wp_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (acc)
                wp_reg <= wp_reg + 1'b1;
            if (cmd_take && cmd_valid)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(acc) - (PW+1)'(cmd_take && cmd_valid);
        end
    end
endmodule

@@ hdl/crlt_back.sv @@
// back end: scans the table, updates the hit entry or fills a free one, queues one result
// depends on crlt_pkg, crlt_ram, assert_macros.svh
`include "assert_macros.svh"
module crlt_back #(
    parameter int unsigned ENTRIES = crlt_pkg::ENTRIES_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    output logic cmd_take,
    input crlt_pkg::cmd_t cmd,
    input logic [31:0] expiry_window,
    input logic [31:0] suspension_time,
    input logic [7:0] crash_limit,
    output logic empty,
    input logic pop,
    output crlt_pkg::result_t res
);
    import crlt_pkg::*;
    localparam int unsigned AW = $clog2(ENTRIES > 1 ? ENTRIES : 2);
    localparam int unsigned DW = KEY_W + 8 + 2*TIME_W;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_UPD, S_OUT} state_t;
    state_t state_reg;
    logic [AW:0] idx_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic hit_reg, free_ok_reg;
    logic [AW-1:0] hit_reg_idx, free_reg;
    logic [DW-1:0] ent_reg;
    result_t res_reg;
    logic res_full_reg;
    cmd_t cur_reg;

    logic we;
    logic [AW-1:0] addr;
    logic [DW-1:0] wdata, rdata;

    crlt_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // entry fields from the registered hit
    logic [KEY_W-1:0] e_key;
    logic [7:0] e_cnt;
    logic [TIME_W-1:0] e_exp, e_sus, now41, win_t, sus_t;
    logic lapsed;
    logic [7:0] inc;
    assign {e_key, e_cnt, e_exp, e_sus} = ent_reg;
    assign now41 = {1'b0, cur_reg.now};
    assign win_t = now41 + TIME_W'(expiry_window);
    assign sus_t = now41 + TIME_W'(suspension_time);
    assign lapsed = (e_exp < now41) && (e_sus <= now41);
    assign inc = (e_cnt == 8'hFF) ? e_cnt : e_cnt + 8'd1;

    logic [AW-1:0] last_idx;
    logic rd_match;
    assign last_idx = AW'(idx_reg - 1'b1);
    assign rd_match = valid_reg[last_idx] && (rdata[DW-1 -: KEY_W] == cur_reg.key);

    // update decision, combinational in S_UPD
    result_t ur;
    logic u_we, u_set, u_clr;
    logic [AW-1:0] u_addr;
    logic [DW-1:0] u_data;
    always_comb
    begin
        ur = '0;
        u_we = 1'b0;
        u_set = 1'b0;
        u_clr = 1'b0;
        u_addr = hit_reg_idx;
        u_data = ent_reg;
        unique case (cur_reg.op)
            OP_CRASH:
            begin
                if (!hit_reg)
                begin
                    if (!free_ok_reg)
                        ur.status = ST_FULL;
                    else
                    begin
                        u_we = 1'b1;
                        u_set = 1'b1;
                        u_addr = free_reg;
                        u_data = {cur_reg.key, 8'd1, win_t, {TIME_W{1'b0}}};
                        ur.crash_count = 8'd1;
                    end
                end
                else
                begin
                    ur.found = 1'b1;
                    u_we = 1'b1;
                    if (lapsed)
                    begin
                        u_data = {e_key, 8'd1, win_t, {TIME_W{1'b0}}};
                        ur.crash_count = 8'd1;
                    end
                    else if (inc >= crash_limit)
                    begin
                        u_data = {e_key, 8'd0, {TIME_W{1'b0}}, sus_t};
                        ur.suspended_now = 1'b1;
                    end
                    else
                    begin
                        u_data = {e_key, inc, e_exp, e_sus};
                        ur.crash_count = inc;
                    end
                end
            end
            OP_CHECK:
            begin
                if (hit_reg)
                begin
                    ur.found = 1'b1;
                    if (lapsed)
                        u_clr = 1'b1;
                    else
                    begin
                        if (e_sus > now41)
                            ur.status = ST_DENY;
                        ur.crash_count = e_cnt;
                    end
                end
            end
            OP_REMOVE:
            begin
                ur.found = hit_reg;
                u_clr = hit_reg;
            end
            default: ;
        endcase
    end

    assign we = (state_reg == S_UPD) && u_we;
    assign addr = (state_reg == S_UPD) ? u_addr : AW'(idx_reg);
    assign wdata = u_data;
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid && !res_full_reg;
    assign empty = !res_full_reg;
    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            res_full_reg <= 1'b0;
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else
        begin
            if (pop && res_full_reg)
                res_full_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        cur_reg <= cmd;
                        idx_reg <= '0;
                        hit_reg <= 1'b0;
                        free_ok_reg <= 1'b0;
                        state_reg <= cmd.scan ? S_READ : S_OUT;
                    end
                end
                S_READ:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    // rdata holds entry idx_reg-1; next read issued in parallel
                    if (!hit_reg && rd_match)
                    begin
                        hit_reg <= 1'b1;
                        hit_reg_idx <= last_idx;
                        ent_reg <= rdata;
                    end
                    if (!free_ok_reg && !valid_reg[last_idx])
                    begin
                        free_ok_reg <= 1'b1;
                        free_reg <= last_idx;
                    end
                    if (idx_reg == (AW+1)'(ENTRIES) || (!hit_reg && rd_match))
                        state_reg <= S_UPD;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_UPD:
                begin
                    // a hit stops the scan early; free slot only matters on a miss
                    if (u_set)
                        valid_reg[u_addr] <= 1'b1;
                    if (u_clr)
                        valid_reg[hit_reg_idx] <= 1'b0;
                    res_reg <= ur;
                    res_full_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_OUT:
                begin
                    res_reg <= '0;
                    res_full_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_take_idle, clk, rst_n, cmd_take |=> (state_reg != S_IDLE))
    `ASSERT_NEVER(a_no_full_take, clk, rst_n, cmd_take && res_full_reg)
    `ASSERT_IMPL(a_upd_fills, clk, rst_n, (state_reg == S_UPD) |=> res_full_reg)
    `ASSERT_NEVER(a_we_only_upd, clk, rst_n, we && (state_reg != S_UPD))
endmodule

@@ hdl/crash_rate_lockout_table_core.sv @@
// top level of the crash rate lockout table
// depends on crlt_pkg, crlt_front, crlt_back, crlt_ram
// a scan reads one table entry per cycle; a command that needs no scan goes straight to its result
// the back end handles one transaction at a time and takes the next only when its result slot is empty
// a two-entry command queue lets the input side take transactions during a scan
// reset clears the valid bits and queues and sets the config registers to reset values; no clearing pass
module crash_rate_lockout_table_core #(
    parameter int unsigned ENTRIES = crlt_pkg::ENTRIES_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic push,
    output logic full,
    input logic [1:0] op,
    input logic guard_active,
    input logic [31:0] user_id,
    input logic [63:0] file_id,
    input logic [15:0] mount_id,
    input logic [39:0] now,
    output logic empty,
    input logic pop,
    output logic [1:0] status,
    output logic found,
    output logic [7:0] crash_count,
    output logic suspended_now,
    input logic cfg_valid,
    output logic cfg_ready,
    input logic [1:0] cfg_index,
    input logic [31:0] cfg_data
);
    import crlt_pkg::*;

    logic [31:0] win_reg, sus_reg;
    logic [7:0] max_reg;
    logic cmd_valid, cmd_take;
    cmd_t cmd;
    result_t res;

    // config registers are always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= EXPIRY_RESET;
            sus_reg <= SUSPEND_RESET;
            max_reg <= MAX_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_EXPIRY: win_reg <= cfg_data;
                REG_SUSPEND: sus_reg <= cfg_data;
                REG_MAX: max_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // front: accept and classify
    crlt_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op),
        .guard_active(guard_active), .user_id(user_id), .file_id(file_id),
        .mount_id(mount_id), .now(now), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .cmd(cmd)
    );

    // back: scan and update
    crlt_back #(.ENTRIES(ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .cmd(cmd), .expiry_window(win_reg), .suspension_time(sus_reg),
        .crash_limit(max_reg), .empty(empty), .pop(pop), .res(res)
    );

    assign status = res.status;
    assign found = res.found;
    assign crash_count = res.crash_count;
    assign suspended_now = res.suspended_now;
endmodule

@@ tb/crash_rate_lockout_table_core_tb.sv @@
// testbench for crash_rate_lockout_table_core: directed table, table fill and overflow, then random traffic
// depends on crlt_pkg and the core; a local lockout table model predicts each result unless a verdict is typed in
`timescale 1ns / 1ps

module crash_rate_lockout_table_core_tb;
    import crlt_pkg::*;

    localparam int NSLOT = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [1:0] op;
    logic guard_active;
    logic [31:0] user_id;
    logic [63:0] file_id;
    logic [15:0] mount_id;
    logic [39:0] now;
    logic empty;
    logic pop;
    logic [1:0] status;
    logic found;
    logic [7:0] crash_count;
    logic suspended_now;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    crash_rate_lockout_table_core uut (.*);

    // item and verdict records
    typedef struct {
        logic [1:0] op;
        logic guard;
        logic [31:0] user;
        logic [63:0] file;
        logic [15:0] mount;
        logic [39:0] now;
    } report_t;

    typedef struct {
        logic [1:0] status;
        logic found;
        logic [7:0] count;
        logic susp;
    } verdict_t;

    // directed row: item plus an optional typed-in verdict
    typedef struct {
        report_t item;
        bit has_verdict;
        verdict_t verdict;
    } row_t;

    // model copy of the table and registers
    logic [31:0] win_q;
    logic [31:0] susp_q;
    logic [7:0] max_q;
    logic slot_used [NSLOT];
    logic [31:0] slot_user [NSLOT];
    logic [63:0] slot_file [NSLOT];
    logic [15:0] slot_mount [NSLOT];
    logic [7:0] slot_count [NSLOT];
    logic [40:0] slot_expiry [NSLOT];
    logic [40:0] slot_until [NSLOT];

    verdict_t pending_verdicts [$];
    int errors = 0;
    int cycles = 0;
    int send_idle = 27;
    int recv_idle = 83;
    int results_seen = 0;
    int reports_sent = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int lookup_slot(report_t r);
        for (int i = 0; i < NSLOT; i++)
            if (slot_used[i] && slot_user[i] == r.user && slot_file[i] == r.file &&
                slot_mount[i] == r.mount)
                return i;
        return -1;
    endfunction

    function automatic bit has_lapsed(int s, logic [39:0] t);
        return slot_expiry[s] < {1'b0, t} && slot_until[s] <= {1'b0, t};
    endfunction

    // apply one item to the model table and return its verdict
    function automatic verdict_t lockout_verdict(report_t r);
        verdict_t v;
        int s;
        v = '{default: '0};
        s = lookup_slot(r);
        if (r.op == OP_CRASH && r.guard)
        begin
            if (s < 0)
            begin
                for (int i = 0; i < NSLOT && s < 0; i++)
                    if (!slot_used[i])
                        s = i;
                if (s < 0)
                    v.status = ST_FULL;
                else
                begin
                    slot_used[s] = 1'b1;
                    slot_user[s] = r.user;
                    slot_file[s] = r.file;
                    slot_mount[s] = r.mount;
                    slot_count[s] = 8'd1;
                    slot_expiry[s] = {1'b0, r.now} + {9'd0, win_q};
                    slot_until[s] = '0;
                    v.count = 8'd1;
                end
            end
            else
            begin
                v.found = 1'b1;
                if (has_lapsed(s, r.now))
                begin
                    slot_count[s] = 8'd1;
                    slot_expiry[s] = {1'b0, r.now} + {9'd0, win_q};
                    slot_until[s] = '0;
                end
                else
                begin
                    if (slot_count[s] != 8'd255)
                        slot_count[s]++;
                    if (slot_count[s] >= max_q)
                    begin
                        slot_until[s] = {1'b0, r.now} + {9'd0, susp_q};
                        slot_count[s] = '0;
                        slot_expiry[s] = '0;
                        v.susp = 1'b1;
                    end
                end
                v.count = slot_count[s];
            end
        end
        else if (r.op == OP_CHECK && r.guard)
        begin
            if (s >= 0)
            begin
                v.found = 1'b1;
                if (has_lapsed(s, r.now))
                    slot_used[s] = 1'b0;
                else
                begin
                    if (slot_until[s] > {1'b0, r.now})
                        v.status = ST_DENY;
                    v.count = slot_count[s];
                end
            end
        end
        else if (r.op == OP_REMOVE && s >= 0)
        begin
            v.found = 1'b1;
            slot_used[s] = 1'b0;
        end
        return v;
    endfunction

    // result side: random pop, compare against oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result transaction with nothing expected");
                errors++;
            end
            else
            begin
                verdict_t e;
                e = pending_verdicts.pop_front();
                results_seen++;
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    errors++;
                end
                if (found !== e.found)
                begin
                    $error("found expected %0d actual %0d", e.found, found);
                    errors++;
                end
                if (crash_count !== e.count)
                begin
                    $error("crash_count expected %0d actual %0d", e.count, crash_count);
                    errors++;
                end
                if (suspended_now !== e.susp)
                begin
                    $error("suspended_now expected %0d actual %0d", e.susp, suspended_now);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= recv_idle);

    // push one item, predicting at acceptance; a typed-in verdict is checked directly
    task automatic send_report(report_t r, bit has_v, verdict_t tv);
        verdict_t v;
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        op <= r.op;
        guard_active <= r.guard;
        user_id <= r.user;
        file_id <= r.file;
        mount_id <= r.mount;
        now <= r.now;
        @(posedge clk);
        while (full)
            @(posedge clk);
        v = lockout_verdict(r);
        pending_verdicts.push_back(has_v ? tv : v);
        reports_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (140) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_EXPIRY: win_q = val;
            REG_SUSPEND: susp_q = val;
            default: max_q = val[7:0];
        endcase
        @(negedge clk);
    endtask

    function automatic report_t make_report(logic [1:0] o, logic g, logic [31:0] u,
        logic [63:0] f, logic [15:0] m, logic [39:0] t);
        report_t r;
        r.op = o; r.guard = g; r.user = u; r.file = f; r.mount = m; r.now = t;
        return r;
    endfunction

    // random item: mostly keys from a small pool so entries get reused
    function automatic report_t random_report(int pool, logic [39:0] t);
        report_t r;
        int k;
        k = $urandom_range(pool - 1);
        r.op = ($urandom_range(99) < 3) ? OP_NONE :
            ($urandom_range(99) < 55) ? OP_CRASH : ($urandom_range(9) < 8 ? OP_CHECK : OP_REMOVE);
        r.guard = ($urandom_range(99) < 90);
        if ($urandom_range(99) < 90)
        begin
            r.user = 32'hF000_0000 ^ 32'(k);
            r.file = 64'hFFFF_0000_0000_0000 ^ 64'(k * 7);
            r.mount = 16'(k) ^ 16'h8001;
        end
        else
        begin
            r.user = $urandom();
            r.file = {$urandom(), $urandom()};
            r.mount = 16'($urandom());
        end
        r.now = t;
        return r;
    endfunction

    initial
    begin
        row_t rows [$];
        verdict_t none;
        logic [39:0] t;
        logic [39:0] hi_t;
        none = '{default: '0};
        hi_t = 40'hFF_FFFF_FFFF;

        rst_n = 1'b0; push = 1'b0; cfg_valid = 1'b0;
        op = OP_NONE; guard_active = 1'b0; user_id = '0; file_id = '0;
        mount_id = '0; now = '0; cfg_index = REG_EXPIRY; cfg_data = '0;
        win_q = EXPIRY_RESET; susp_q = SUSPEND_RESET; max_q = MAX_RESET;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, reset registers first
        rows.push_back('{make_report(OP_CHECK, 1, 1, 1, 1, 10), 1, none});
        rows.push_back('{make_report(OP_CRASH, 0, 1, 1, 1, 10), 1, none});
        rows.push_back('{make_report(OP_CRASH, 1, 1, 1, 1, 10), 1, '{ST_ALLOW, 0, 1, 0}});
        for (int i = 0; i < 4; i++)
            rows.push_back('{make_report(OP_CRASH, 1, 1, 1, 1, 11 + i), 0, none});
        rows.push_back('{make_report(OP_CHECK, 1, 1, 1, 1, 20), 1, '{ST_DENY, 1, 0, 0}});
        rows.push_back('{make_report(OP_CHECK, 0, 1, 1, 1, 20), 1, none});
        rows.push_back('{make_report(OP_CHECK, 1, 1, 1, 1, 900), 1, '{ST_ALLOW, 1, 0, 0}});
        rows.push_back('{make_report(OP_CRASH, 1, '1, '1, '1, hi_t), 1, '{ST_ALLOW, 0, 1, 0}});
        rows.push_back('{make_report(OP_CRASH, 1, '1, '1, '1, hi_t), 0, none});
        rows.push_back('{make_report(OP_NONE, 1, '1, '1, '1, hi_t), 1, none});
        rows.push_back('{make_report(OP_REMOVE, 0, '1, '1, '1, hi_t), 1, '{ST_ALLOW, 1, 0, 0}});
        rows.push_back('{make_report(OP_REMOVE, 1, '1, '1, '1, hi_t), 1, none});
        rows.push_back('{make_report(OP_CRASH, 1, 0, 0, 0, 0), 1, '{ST_ALLOW, 0, 1, 0}});
        rows.push_back('{make_report(OP_CRASH, 1, 0, 0, 0, 500), 0, none});
        foreach (rows[i])
            send_report(rows[i].item, rows[i].has_verdict, rows[i].verdict);
        drain_results();

        // fill the table with distinct keys, then overflow it
        for (int i = 0; i < NSLOT + 2; i++)
            send_report(make_report(OP_CRASH, 1, 32'(i) + 100, 64'(i), 16'(i), 1000),
                i >= NSLOT, '{ST_FULL, 0, 0, 0});
        for (int i = 0; i < NSLOT; i++)
            send_report(make_report(OP_REMOVE, 1, 32'(i) + 100, 64'(i), 16'(i), 1000), 0, none);
        drain_results();

        // random phases over several register settings and idle profiles
        t = 40'd5000;
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_results();
            case (ph)
                0: begin write_reg(REG_EXPIRY, 32'd0); write_reg(REG_SUSPEND, 32'd0);
                    write_reg(REG_MAX, 32'd0); end
                1: begin write_reg(REG_EXPIRY, 32'hFFFF_FFFF);
                    write_reg(REG_SUSPEND, 32'hFFFF_FFFF);
                    write_reg(REG_MAX, 32'd255); end
                2: begin write_reg(REG_EXPIRY, 32'd30); write_reg(REG_SUSPEND, 32'd50);
                    write_reg(REG_MAX, 32'd1); end
                default: begin write_reg(REG_EXPIRY, $urandom_range(80));
                    write_reg(REG_SUSPEND, $urandom_range(200));
                    write_reg(REG_MAX, $urandom_range(1, 6)); end
            endcase
            cfg_valid <= 1'b0;
            if (ph == 2) begin send_idle = 83; recv_idle = 27; end
            if (ph == 4) begin send_idle = 0; recv_idle = 0; end
            if (ph == 5) t = 40'hFF_FFFF_0000;
            for (int n = 0; n < 200; n++)
            begin
                t = t + 40'($urandom_range(12));
                send_report(random_report(ph == 1 ? 70 : 12, t), 0, none);
            end
        end
        drain_results();

        $display("covered %0d transactions and %0d results over six register settings",
            reports_sent, results_seen);
        $display("full table, deny, lapse, remove, guard off and saturating counts exercised");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
